### sv/assert_macros.svh
// assertion helpers used by the top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### sv/lcdns_pkg.sv
// ----------------------------------------------------------------------------
// lcdns_pkg
// Shared types, codes and byte tables of the character lcd nibble sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdns_pkg;

   // request operation codes
   localparam logic [2:0] OP_INIT        = 3'd0;
   localparam logic [2:0] OP_WRITE_START = 3'd1;
   localparam logic [2:0] OP_WRITE_CHAR  = 3'd2;
   localparam logic [2:0] OP_START_EDIT  = 3'd3;
   localparam logic [2:0] OP_EDIT_CHAR   = 3'd4;
   localparam logic [2:0] OP_FINISH_EDIT = 3'd5;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BUSY      = 2'd1;
   localparam logic [1:0] ST_BAD_ADDR  = 2'd2;
   localparam logic [1:0] ST_CLIPPED   = 2'd3;

   // display geometry
   localparam logic [6:0] LINE2_FIRST = 7'd64;
   localparam logic [6:0] LINE1_STOP  = 7'h28;
   localparam logic [6:0] LINE2_STOP  = 7'h67;

   // controller commands
   localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
   localparam logic [7:0] CMD_CURSOR_ON  = 8'h0D;
   localparam logic [7:0] CMD_SET_ADDR   = 8'h80;

   // expander pins
   localparam logic [7:0] PIN_E  = 8'h04;
   localparam logic [7:0] PIN_BL = 8'h08;
   localparam logic [7:0] PIN_RS = 8'h01;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;

   typedef enum logic [1:0] {
      JOB_REJECT = 2'd0,
      JOB_INIT   = 2'd1,
      JOB_BYTES  = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [1:0]   status;
      logic [7:0]   byte0;
      logic         rs0;
      logic [7:0]   byte1;
      logic         rs1;
      logic         two;
   } job_type;

   // one expander byte of a full byte: phase 0/1 high nibble, 2/3 low nibble,
   // enable high on even phases
   function automatic logic [7:0] nibble_byte(input logic [7:0] b,
                                              input logic [1:0] phase,
                                              input logic       rs);
      logic [7:0] v;
      v = phase[1] ? {b[3:0], 4'h0} : {b[7:4], 4'h0};
      if (!phase[0]) v = v | PIN_E;
      v = v | PIN_BL | (rs ? PIN_RS : 8'h00);
      return v;
   endfunction

   // fixed start sequence, backlight on, enable toggled
   function automatic logic [7:0] init_byte(input logic [3:0] idx);
      logic [7:0] v;
      unique case (idx)
         4'd0, 4'd2, 4'd4: v = 8'h3C;
         4'd1, 4'd3, 4'd5: v = 8'h38;
         4'd6:  v = 8'h2C;
         4'd7:  v = 8'h28;
         4'd8:  v = 8'h2C;
         4'd9:  v = 8'h28;
         4'd10: v = 8'h8C;
         4'd11: v = 8'h88;
         4'd12: v = 8'h0C;
         4'd13: v = 8'h08;
         4'd14: v = 8'hCC;
         4'd15: v = 8'hC8;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic logic address_bad(input logic [6:0] a);
      return ((a >= LINE1_STOP) && (a < LINE2_FIRST)) || (a >= LINE2_STOP);
   endfunction

endpackage

`default_nettype wire

### sv/lcdns_front.sv
// ----------------------------------------------------------------------------
// lcdns_front
// Checks each request against the display state, updates that state and
// turns the request into a job for the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdns_front import lcdns_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [2:0] operation,
   input  wire logic [6:0] char_address,
   input  wire logic [7:0] char_code,
   input  wire logic       last_char,
   output job_type         job
);

   logic       initialized_ff, initialized_in;
   logic       edit_mode_ff, edit_mode_in;
   logic [6:0] base_address_ff, base_address_in;
   logic [6:0] char_offset_ff, char_offset_in;
   logic       string_open_ff, string_open_in;
   logic       string_clipped_ff, string_clipped_in;
   logic [6:0] pos;

   assign pos = base_address_ff + char_offset_ff;

   always_comb begin
      initialized_in    = initialized_ff;
      edit_mode_in      = edit_mode_ff;
      base_address_in   = base_address_ff;
      char_offset_in    = char_offset_ff;
      string_open_in    = string_open_ff;
      string_clipped_in = string_clipped_ff;
      job.kind   = JOB_REJECT;
      job.status = ST_BUSY;
      job.byte0  = char_code;
      job.rs0    = 1'b0;
      job.byte1  = CMD_SET_ADDR | {1'b0, base_address_ff};
      job.rs1    = 1'b0;
      job.two    = 1'b0;
      unique case (operation)
         OP_INIT: begin
            if (!string_open_ff) begin
               job.kind       = JOB_INIT;
               job.status     = ST_OK;
               initialized_in = 1'b1;
               edit_mode_in   = 1'b0;
            end
         end
         OP_WRITE_START: begin
            if (initialized_ff && !string_open_ff && !edit_mode_ff) begin
               if (address_bad(char_address)) begin
                  job.status = ST_BAD_ADDR;
               end else begin
                  job.kind          = JOB_BYTES;
                  job.status        = ST_OK;
                  job.byte0         = CMD_SET_ADDR | {1'b0, char_address};
                  base_address_in   = char_address;
                  char_offset_in    = 7'd0;
                  string_open_in    = 1'b1;
                  string_clipped_in = 1'b0;
               end
            end
         end
         OP_WRITE_CHAR: begin
            if (initialized_ff && string_open_ff) begin
               if (last_char) string_open_in = 1'b0;
               // past a line end the rest of the string is dropped
               if (string_clipped_ff || pos == LINE1_STOP || pos == LINE2_STOP) begin
                  job.status        = ST_CLIPPED;
                  string_clipped_in = 1'b1;
               end else begin
                  job.kind       = JOB_BYTES;
                  job.status     = ST_OK;
                  job.rs0        = 1'b1;
                  char_offset_in = char_offset_ff + 7'd1;
               end
            end
         end
         OP_START_EDIT: begin
            if (initialized_ff && !string_open_ff) begin
               if (address_bad(char_address)) begin
                  job.status = ST_BAD_ADDR;
               end else begin
                  job.kind        = JOB_BYTES;
                  job.status      = ST_OK;
                  job.byte0       = CMD_SET_ADDR | {1'b0, char_address};
                  job.byte1       = CMD_CURSOR_ON;
                  job.two         = 1'b1;
                  base_address_in = char_address;
                  edit_mode_in    = 1'b1;
               end
            end
         end
         OP_EDIT_CHAR: begin
            if (initialized_ff && !string_open_ff) begin
               job.kind   = JOB_BYTES;
               job.status = ST_OK;
               job.rs0    = 1'b1;
               // re-address puts the cursor back in edit mode
               job.two    = edit_mode_ff;
            end
         end
         OP_FINISH_EDIT: begin
            if (initialized_ff && !string_open_ff) begin
               job.kind     = JOB_BYTES;
               job.status   = ST_OK;
               job.byte0    = CMD_DISPLAY_ON;
               edit_mode_in = 1'b0;
            end
         end
         default: begin
            job.status = ST_BUSY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         initialized_ff    <= 1'b0;
         edit_mode_ff      <= 1'b0;
         base_address_ff   <= 7'd0;
         char_offset_ff    <= 7'd0;
         string_open_ff    <= 1'b0;
         string_clipped_ff <= 1'b0;
      end else if (accept) begin
         initialized_ff    <= initialized_in;
         edit_mode_ff      <= edit_mode_in;
         base_address_ff   <= base_address_in;
         char_offset_ff    <= char_offset_in;
         string_open_ff    <= string_open_in;
         string_clipped_ff <= string_clipped_in;
      end
   end

endmodule

`default_nettype wire

### sv/lcdns_queue.sv
// ----------------------------------------------------------------------------
// lcdns_queue
// Short job queue that lets the front and the byte sequencer stall apart.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdns_queue import lcdns_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output job_type      head_job,
   output logic         head_valid,
   output logic         full,
   output logic         empty
);

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;

   assign full       = count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign empty      = count_ff == '0;
   assign head_valid = !empty;
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_PTR_W+1)'(push) - (QUEUE_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule

`default_nettype wire

### sv/lcdns_back.sv
// ----------------------------------------------------------------------------
// lcdns_back
// Byte sequencer: plays out the job at the head of the queue into the result
// register, one result (expander byte or rejection) per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdns_back import lcdns_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire job_type    head_job,
   input  wire logic       head_valid,
   output logic            pop,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_bus_byte,
   output logic            rsp_byte_valid,
   output logic [1:0]      rsp_status,
   output logic            rsp_last_result
);

   logic [3:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       bvalid_ff, bvalid_in;
   logic [1:0] status_ff, status_in;
   logic       last_ff, last_in;
   logic       advance;
   logic [7:0] cur_byte;
   logic       cur_rs;

   assign advance  = head_valid && (!valid_ff || !rsp_stall);
   assign cur_byte = step_ff[2] ? head_job.byte1 : head_job.byte0;
   assign cur_rs   = step_ff[2] ? head_job.rs1 : head_job.rs0;

   always_comb begin
      byte_in   = 8'h00;
      bvalid_in = 1'b1;
      status_in = ST_OK;
      last_in   = 1'b1;
      unique case (head_job.kind)
         JOB_REJECT: begin
            bvalid_in = 1'b0;
            status_in = head_job.status;
         end
         JOB_INIT: begin
            byte_in = init_byte(step_ff);
            last_in = step_ff == 4'd15;
         end
         JOB_BYTES: begin
            byte_in = nibble_byte(cur_byte, step_ff[1:0], cur_rs);
            last_in = step_ff == (head_job.two ? 4'd7 : 4'd3);
         end
         default: begin
            bvalid_in = 1'b0;
            status_in = ST_BUSY;
         end
      endcase
      pop      = advance && last_in;
      step_in  = step_ff;
      if (advance) step_in = last_in ? 4'd0 : step_ff + 4'd1;
      valid_in = advance ? 1'b1 : (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff   <= byte_in;
         bvalid_ff <= bvalid_in;
         status_ff <= status_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_bus_byte    = byte_ff;
   assign rsp_byte_valid  = bvalid_ff;
   assign rsp_status      = status_ff;
   assign rsp_last_result = last_ff;

endmodule

`default_nettype wire

### sv/char_lcd_nibble_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// Character lcd driver in 4-bit mode over an 8-bit port expander.
// ----------------------------------------------------------------------------
// Requests come in on the req_ channel (valid/stall), one operation each.
// Every request yields results on the rsp_ channel, the final one flagged by
// rsp_last_result: a single rejection result (byte_valid low, status code),
// or the expander bytes of the request, one per transfer.
// Byte counts: init 16, write start, write char, finish edit 4, start edit 8,
// edit char 4 or 8 (with re-address in edit mode).
// A request's job is first written into the job queue, and the sequencer
// then moves its first result into the result register.
// The byte sequencer issues one result per cycle while rsp_stall is low and
// finishes one request's results before it starts the next (a character has 4).
// A two-entry job queue lets requests be taken while earlier bytes still go
// out; req_stall rises only when that queue is full.
// Reset clears the display state (not initialized, write mode, no string)
// and empties the queue and result register.
// When the receiver stalls, the result register holds its byte and the
// sequencer waits; the queue then fills and stalls the request side.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module char_lcd_nibble_sequencer import lcdns_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_operation,
   input  wire logic [6:0] req_char_address,
   input  wire logic [7:0] req_char_code,
   input  wire logic       req_last_char,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_bus_byte,
   output logic            rsp_byte_valid,
   output logic [1:0]      rsp_status,
   output logic            rsp_last_result
);

   job_type new_job;
   job_type head_job;
   logic    head_valid;
   logic    q_full;
   logic    q_empty;
   logic    pop;
   logic    accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   lcdns_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .operation    (req_operation),
      .char_address (req_char_address),
      .char_code    (req_char_code),
      .last_char    (req_last_char),
      .job          (new_job)
   );

   lcdns_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_job   (new_job),
      .pop        (pop),
      .head_job   (head_job),
      .head_valid (head_valid),
      .full       (q_full),
      .empty      (q_empty)
   );

   lcdns_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_job        (head_job),
      .head_valid      (head_valid),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_bus_byte    (rsp_bus_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_status      (rsp_status),
      .rsp_last_result (rsp_last_result)
   );

   // rejections carry no byte and end their request
   `ASSERT_CLKD(a_reject_shape, clock, reset, (rsp_valid && rsp_status != ST_OK) |-> (!rsp_byte_valid && rsp_last_result && rsp_bus_byte == 8'h00), "rejection result malformed")

   // every sent byte keeps the backlight on and is an accepted result
   `ASSERT_CLKD(a_byte_shape, clock, reset, (rsp_valid && rsp_byte_valid) |-> (rsp_status == ST_OK && rsp_bus_byte[3]), "expander byte malformed")

   // a request into an idle block passes through the job queue and then shows a result
   `ASSERT_CLKD(a_idle_latency, clock, reset, (accept && q_empty && !rsp_valid) |=> ##1 rsp_valid, "result missing after idle request")

   // the sequencer never pops an empty queue
   `ASSERT_NEVER(a_pop_empty, clock, reset, pop && q_empty, "pop from empty job queue")

endmodule

`default_nettype wire
